// File: design/wtd_pkg.sv
package wtd_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 64;

    // Command codes carried on s_tuser.
    localparam logic CMD_SUBMIT   = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    // Configuration register index (byte address 4 * index).
    localparam logic REG_WORKER_COUNT = 1'b0;
    localparam logic [4:0] WORKER_COUNT_RST = 5'd1;

    localparam logic [1:0] STRESS_LOW  = 2'd0;
    localparam logic [1:0] STRESS_MID  = 2'd1;
    localparam logic [1:0] STRESS_HIGH = 2'd2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    // Classified command, as it travels from the front to the back.
    typedef struct packed {
        logic        is_complete;
        logic        bad_worker;
        logic [15:0] task_id;
        logic [15:0] task_type;
        logic [3:0]  worker_id;
    } item_t;

    typedef struct packed {
        logic        dispatch_valid;
        logic [3:0]  dispatch_worker;
        logic [15:0] dispatch_task;
        logic [15:0] dispatch_type;
        logic        queued;
        logic        dropped;
        logic        bad_worker;
        logic [6:0]  pending_count;
        logic [1:0]  stress;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

// File: design/worker_task_dispatcher_top.sv
// Channel  | Direction | Signals                     | Contents
// input    | in        | s_tvalid/s_tready/s_tdata   | tuser = command, tdata = task and worker
// result   | out       | m_tvalid/m_tready/m_tdata   | one result per accepted command
// config   | in        | psel/penable/pwrite/paddr   | worker_count at byte address 0
//
// The execution unit takes each command from the queue while it reads the head of the
// pending store (registered read port), then updates the worker state and the store.
// An input register and a two-entry command queue let submission continue while
// the execution unit waits on a stalled result register.
// Reset is synchronous and active low; it idles all workers and empties the store.
module worker_task_dispatcher_top #(
    parameter int MAX_WORKERS = wtd_pkg::MAX_WORKERS_DEF,
    parameter int QUEUE_DEPTH = wtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] task_id, [31:16] task_type, [35:32] worker_id, [39:36] zero
    input  logic [wtd_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] dispatch_valid, [4:1] dispatch_worker, [20:5] dispatch_task,
    // [36:21] dispatch_type, [37] queued, [38] dropped, [39] bad_worker,
    // [46:40] pending_count, [48:47] stress, [55:49] zero
    output logic [wtd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(MAX_WORKERS + 1);

    logic [4:0]       worker_count_reg;
    logic [AW-1:0]    active_workers;
    logic             push_valid;
    logic             push_ready;
    wtd_pkg::item_t   push_item;
    logic             q_valid;
    logic             q_pop;
    wtd_pkg::item_t   q_item;
    wtd_pkg::result_t result;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == wtd_pkg::REG_WORKER_COUNT);
    assign prdata    = (paddr[2] == wtd_pkg::REG_WORKER_COUNT) ? {27'd0, worker_count_reg}
                                                               : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            worker_count_reg <= wtd_pkg::WORKER_COUNT_RST;
        end else if (cfg_write) begin
            worker_count_reg <= pwdata[4:0];
        end
    end

    // A count of zero behaves as one worker; larger counts clamp to the pool size.
    always_comb begin
        if (worker_count_reg == 5'd0) begin
            active_workers = AW'(1);
        end else if (int'(worker_count_reg) > MAX_WORKERS) begin
            active_workers = AW'(MAX_WORKERS);
        end else begin
            active_workers = AW'(worker_count_reg);
        end
    end

    wtd_front #(
        .MAX_WORKERS(MAX_WORKERS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .active_workers (active_workers),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    wtd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    wtd_back #(
        .MAX_WORKERS(MAX_WORKERS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .active_workers (active_workers),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_result       (result)
    );

    assign m_tdata = {7'd0, result.stress, result.pending_count, result.bad_worker,
                      result.dropped, result.queued, result.dispatch_type,
                      result.dispatch_task, result.dispatch_worker, result.dispatch_valid};

    // A task is either dispatched, queued or dropped, never two of these.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result.dispatch_valid && (result.queued || result.dropped)))
        else $error("dispatch reported together with queued or dropped");

    // Submit flags and the completion flag never appear in the same result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result.bad_worker && (result.queued || result.dropped)))
        else $error("bad worker flag on a submit result");

    // Without a dispatch the dispatch fields are cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !result.dispatch_valid) |->
            (result.dispatch_worker == 4'd0 && result.dispatch_task == 16'd0 &&
             result.dispatch_type == 16'd0))
        else $error("dispatch fields not cleared");

    // The load level is always one of the three defined codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (result.stress == wtd_pkg::STRESS_LOW ||
                      result.stress == wtd_pkg::STRESS_MID ||
                      result.stress == wtd_pkg::STRESS_HIGH))
        else $error("undefined load level");

endmodule

// File: design/wtd_front.sv
module wtd_front #(
    parameter int MAX_WORKERS = wtd_pkg::MAX_WORKERS_DEF,
    localparam int AW = $clog2(MAX_WORKERS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [AW-1:0]                active_workers,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wtd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    output logic                         push_valid,
    input  logic                         push_ready,
    output wtd_pkg::item_t               push_item
);

    logic           valid_reg;
    logic           valid_next;
    wtd_pkg::item_t item_reg;
    wtd_pkg::item_t item_class;
    logic           s_accept;

    assign s_tready = !valid_reg || push_ready;
    assign s_accept = s_tvalid && s_tready;

    // Decode the command and, for a completion, check the worker index against the active pool.
    always_comb begin
        item_class.is_complete = (s_tuser == wtd_pkg::CMD_COMPLETE);
        item_class.task_id     = s_tdata[15:0];
        item_class.task_type   = s_tdata[31:16];
        item_class.worker_id   = s_tdata[35:32];
        item_class.bad_worker  = (s_tuser == wtd_pkg::CMD_COMPLETE) &&
                                 (int'(s_tdata[35:32]) >= int'(active_workers));
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_accept) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_class;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// File: design/wtd_queue.sv
module wtd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  wtd_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output wtd_pkg::item_t pop_item
);

    wtd_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/wtd_back.sv
module wtd_back #(
    parameter int MAX_WORKERS = wtd_pkg::MAX_WORKERS_DEF,
    parameter int QUEUE_DEPTH = wtd_pkg::QUEUE_DEPTH_DEF,
    localparam int AW   = $clog2(MAX_WORKERS + 1),
    localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
    localparam int HW   = $clog2(QUEUE_DEPTH),
    localparam int FW   = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [AW-1:0]     active_workers,
    input  logic              q_valid,
    input  wtd_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output wtd_pkg::result_t  m_result
);

    wtd_pkg::back_state_t state_reg;
    wtd_pkg::back_state_t state_next;

    wtd_pkg::item_t       item_reg;
    logic [MAX_WORKERS-1:0] busy_reg;
    logic [MAX_WORKERS-1:0] busy_next;
    logic [HW-1:0]        head_reg;
    logic [HW-1:0]        head_next;
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        fill_next;

    logic [31:0]          pending_mem [QUEUE_DEPTH];
    logic [31:0]          rd_data_reg;
    logic                 mem_we;
    logic [HW-1:0]        wr_slot;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    wtd_pkg::result_t     out_reg;
    wtd_pkg::result_t     res;

    logic                 fire;
    logic [MAX_WORKERS-1:0] busy_mid;
    logic                 idle_found;
    logic [WIDX-1:0]      idle_idx;
    logic [WIDX+3:0]      idle_wide;
    logic [FW+6:0]        fill_wide;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wtd_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = wtd_pkg::BK_EXEC;
                end
            end
            wtd_pkg::BK_EXEC: begin
                if (fire) begin
                    state_next = wtd_pkg::BK_IDLE;
                end
            end
            default: state_next = wtd_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop = 1'b0;
        fire  = 1'b0;
        case (state_reg)
            wtd_pkg::BK_IDLE: q_pop = q_valid;
            wtd_pkg::BK_EXEC: fire  = !out_valid_reg || m_ready;
            default: begin
                q_pop = 1'b0;
                fire  = 1'b0;
            end
        endcase
    end

    // A completion frees its worker before the search for an idle one.
    always_comb begin
        busy_mid = busy_reg;
        if (item_reg.is_complete && !item_reg.bad_worker) begin
            for (int i = 0; i < MAX_WORKERS; i++) begin
                if (int'(item_reg.worker_id) == i) begin
                    busy_mid[i] = 1'b0;
                end
            end
        end
    end

    // Lowest idle worker inside the active pool.
    always_comb begin
        idle_found = 1'b0;
        idle_idx   = '0;
        for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
            if (!busy_mid[i] && (i < int'(active_workers))) begin
                idle_found = 1'b1;
                idle_idx   = WIDX'(i);
            end
        end
    end

    always_comb begin
        int sum;
        sum       = int'(head_reg) + int'(fill_reg);
        if (sum >= QUEUE_DEPTH) begin
            sum = sum - QUEUE_DEPTH;
        end
        wr_slot   = HW'(sum);
        idle_wide = (WIDX + 4)'(idle_idx);

        busy_next = busy_reg;
        head_next = head_reg;
        fill_next = fill_reg;
        mem_we    = 1'b0;
        res       = '0;

        if (!item_reg.is_complete) begin
            if (idle_found) begin
                res.dispatch_valid  = 1'b1;
                res.dispatch_worker = idle_wide[3:0];
                res.dispatch_task   = item_reg.task_id;
                res.dispatch_type   = item_reg.task_type;
                busy_next           = busy_mid;
                for (int i = 0; i < MAX_WORKERS; i++) begin
                    if (WIDX'(i) == idle_idx) begin
                        busy_next[i] = 1'b1;
                    end
                end
            end else if (int'(fill_reg) < QUEUE_DEPTH) begin
                mem_we     = 1'b1;
                fill_next  = fill_reg + FW'(1);
                res.queued = 1'b1;
            end else begin
                res.dropped = 1'b1;
            end
        end else begin
            res.bad_worker = item_reg.bad_worker;
            busy_next      = busy_mid;
            if ((fill_reg != '0) && idle_found) begin
                res.dispatch_valid  = 1'b1;
                res.dispatch_worker = idle_wide[3:0];
                res.dispatch_task   = rd_data_reg[15:0];
                res.dispatch_type   = rd_data_reg[31:16];
                for (int i = 0; i < MAX_WORKERS; i++) begin
                    if (WIDX'(i) == idle_idx) begin
                        busy_next[i] = 1'b1;
                    end
                end
                head_next = (int'(head_reg) == QUEUE_DEPTH - 1) ? '0 : head_reg + HW'(1);
                fill_next = fill_reg - FW'(1);
            end
        end

        fill_wide         = (FW + 7)'(fill_next);
        res.pending_count = fill_wide[6:0];
        if (int'(fill_next) < int'(active_workers)) begin
            res.stress = wtd_pkg::STRESS_LOW;
        end else if (int'(fill_next) <= 2 * int'(active_workers)) begin
            res.stress = wtd_pkg::STRESS_MID;
        end else begin
            res.stress = wtd_pkg::STRESS_HIGH;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wtd_pkg::BK_IDLE;
            busy_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                busy_reg <= busy_next;
                head_reg <= head_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (fire) begin
            out_reg <= res;
        end
    end

    // The head entry is read every cycle; it only moves, and the store is only
    // written, on the cycle a command completes, so the next command sees it.
    always_ff @(posedge aclk) begin
        if (fire && mem_we) begin
            pending_mem[wr_slot] <= {item_reg.task_type, item_reg.task_id};
        end
        rd_data_reg <= pending_mem[head_reg];
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

// File: tb/worker_task_dispatcher_top_tb.sv
module worker_task_dispatcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int STALL_CYCLES = 300;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [4:0]       cfg_val;
        logic             cmd;
        logic [15:0]      task_id;
        logic [15:0]      task_type;
        logic [3:0]       worker_id;
        wtd_pkg::result_t want;
    } row_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [wtd_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = wtd_pkg::CMD_SUBMIT;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [wtd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // Shadow copy of the dispatcher state.
    logic [4:0]  cfg_workers = wtd_pkg::WORKER_COUNT_RST;
    logic [15:0] busy_mask = '0;
    logic [31:0] wait_store [wtd_pkg::QUEUE_DEPTH_DEF];
    int          wait_head = 0;
    int          wait_fill = 0;

    wtd_pkg::result_t expected_dispatches [$];
    int      fail_count = 0;
    int      source_idle_pct = 8;
    int      sink_idle_pct = 77;
    int      hold_req = 0;
    int      hold_done = 0;

    row_t directed_rows [23] = '{
        '{ROW_TYPED, 5'd0, wtd_pkg::CMD_SUBMIT, 16'hFFFF, 16'hFFFF, 4'hF,
          '{1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 7'd0, wtd_pkg::STRESS_LOW}},
        '{ROW_TYPED, 5'd0, wtd_pkg::CMD_SUBMIT, 16'h0000, 16'h0000, 4'h0,
          '{1'b0, 4'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 7'd1, wtd_pkg::STRESS_MID}},
        '{ROW_TYPED, 5'd0, wtd_pkg::CMD_COMPLETE, 16'h0000, 16'h0000, 4'hF,
          '{1'b0, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 7'd1, wtd_pkg::STRESS_MID}},
        '{ROW_TYPED, 5'd0, wtd_pkg::CMD_COMPLETE, 16'h0000, 16'h0000, 4'h0,
          '{1'b1, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd0, wtd_pkg::STRESS_LOW}},
        '{ROW_TYPED, 5'd0, wtd_pkg::CMD_COMPLETE, 16'hFFFF, 16'hFFFF, 4'h0,
          '{1'b0, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 7'd0, wtd_pkg::STRESS_LOW}},
        '{ROW_CFG,     5'd0,  wtd_pkg::CMD_SUBMIT,   16'h0000, 16'h0000, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_SUBMIT,   16'h1234, 16'hABCD, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_SUBMIT,   16'h5555, 16'hAAAA, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_COMPLETE, 16'h0000, 16'h0000, 4'h1, '0},
        '{ROW_CFG,     5'd31, wtd_pkg::CMD_SUBMIT,   16'h0000, 16'h0000, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_SUBMIT,   16'hAAAA, 16'h5555, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_COMPLETE, 16'h0000, 16'h0000, 4'hF, '0},
        '{ROW_CFG,     5'd17, wtd_pkg::CMD_SUBMIT,   16'h0000, 16'h0000, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_SUBMIT,   16'h0F0F, 16'hF0F0, 4'h0, '0},
        '{ROW_CFG,     5'd2,  wtd_pkg::CMD_SUBMIT,   16'h0000, 16'h0000, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_SUBMIT,   16'h3C3C, 16'hC3C3, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_COMPLETE, 16'h0000, 16'h0000, 4'h3, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_COMPLETE, 16'h0000, 16'h0000, 4'h1, '0},
        '{ROW_CFG,     5'd16, wtd_pkg::CMD_SUBMIT,   16'h0000, 16'h0000, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_COMPLETE, 16'h0000, 16'h0000, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_SUBMIT,   16'h8001, 16'h7FFE, 4'h0, '0},
        '{ROW_PREDICT, 5'd0,  wtd_pkg::CMD_SUBMIT,   16'h7FFF, 16'h8000, 4'h0, '0},
        '{ROW_CFG,     5'd1,  wtd_pkg::CMD_SUBMIT,   16'h0000, 16'h0000, 4'h0, '0}
    };

    int bias_menu [4] = '{25, 50, 70, 85};

    worker_task_dispatcher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // A count of zero behaves as one worker, anything above the pool size as the full pool.
    function automatic int live_workers();
        if (cfg_workers == 5'd0) begin
            return 1;
        end else if (int'(cfg_workers) > wtd_pkg::MAX_WORKERS_DEF) begin
            return wtd_pkg::MAX_WORKERS_DEF;
        end
        return int'(cfg_workers);
    endfunction

    function automatic int first_idle(input int n);
        for (int i = 0; i < n; i++) begin
            if (!busy_mask[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic wtd_pkg::result_t predict_dispatch(input logic cmd,
                                                          input logic [15:0] tid,
                                                          input logic [15:0] ttype,
                                                          input logic [3:0] wid);
        wtd_pkg::result_t r;
        int n;
        int idle;
        logic [31:0] head;
        r = '0;
        n = live_workers();
        if (cmd == wtd_pkg::CMD_SUBMIT) begin
            idle = first_idle(n);
            if (idle >= 0) begin
                busy_mask[idle] = 1'b1;
                r.dispatch_valid = 1'b1;
                r.dispatch_worker = 4'(idle);
                r.dispatch_task = tid;
                r.dispatch_type = ttype;
            end else if (wait_fill < wtd_pkg::QUEUE_DEPTH_DEF) begin
                wait_store[(wait_head + wait_fill) % wtd_pkg::QUEUE_DEPTH_DEF] = {ttype, tid};
                wait_fill++;
                r.queued = 1'b1;
            end else begin
                r.dropped = 1'b1;
            end
        end else begin
            if (int'(wid) < n) begin
                busy_mask[wid] = 1'b0;
            end else begin
                r.bad_worker = 1'b1;
            end
            // The head leaves the store only when a worker actually takes it.
            if (wait_fill > 0) begin
                idle = first_idle(n);
                if (idle >= 0) begin
                    head = wait_store[wait_head];
                    busy_mask[idle] = 1'b1;
                    r.dispatch_valid = 1'b1;
                    r.dispatch_worker = 4'(idle);
                    r.dispatch_task = head[15:0];
                    r.dispatch_type = head[31:16];
                    wait_head = (wait_head + 1) % wtd_pkg::QUEUE_DEPTH_DEF;
                    wait_fill--;
                end
            end
        end
        r.pending_count = 7'(wait_fill);
        if (wait_fill < n) begin
            r.stress = wtd_pkg::STRESS_LOW;
        end else if (wait_fill <= 2 * n) begin
            r.stress = wtd_pkg::STRESS_MID;
        end else begin
            r.stress = wtd_pkg::STRESS_HIGH;
        end
        return r;
    endfunction

    task automatic offer_command(input logic cmd, input logic [15:0] tid,
                                 input logic [15:0] ttype, input logic [3:0] wid,
                                 input logic typed, input wtd_pkg::result_t want);
        wtd_pkg::result_t predicted;
        if ($urandom_range(99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < source_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, wid, ttype, tid};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_dispatch(cmd, tid, ttype, wid);
        expected_dispatches.push_back(typed ? want : predicted);
    endtask

    task automatic set_worker_count(input logic [4:0] value);
        s_tvalid <= 1'b0;
        while (expected_dispatches.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {wtd_pkg::REG_WORKER_COUNT, 2'b00};
        // Bits above the register width carry junk and must be ignored.
        pwdata <= {27'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_workers = value;
    endtask

    task automatic check_dispatch(input wtd_pkg::result_t got);
        wtd_pkg::result_t want;
        if (expected_dispatches.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("result transfer %h arrived with nothing expected", got);
            end
        end else begin
            want = expected_dispatches.pop_front();
            if (got.dispatch_valid !== want.dispatch_valid ||
                got.dispatch_worker !== want.dispatch_worker ||
                got.dispatch_task !== want.dispatch_task ||
                got.dispatch_type !== want.dispatch_type ||
                got.queued !== want.queued ||
                got.dropped !== want.dropped ||
                got.bad_worker !== want.bad_worker ||
                got.pending_count !== want.pending_count ||
                got.stress !== want.stress) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("mismatch expected %p", want);
                    $display("         actual   %p", got);
                end
            end
        end
    endtask

    initial begin : result_sink
        wtd_pkg::result_t got;
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.dispatch_valid = m_tdata[0];
                got.dispatch_worker = m_tdata[4:1];
                got.dispatch_task = m_tdata[20:5];
                got.dispatch_type = m_tdata[36:21];
                got.queued = m_tdata[37];
                got.dropped = m_tdata[38];
                got.bad_worker = m_tdata[39];
                got.pending_count = m_tdata[46:40];
                got.stress = m_tdata[48:47];
                check_dispatch(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) begin
                    hold_done++;
                end
                m_tready <= 1'b0;
            end else if (hold_req != hold_done) begin
                // Long back-pressure so the input side fills and stalls.
                hold_left = STALL_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("worker_task_dispatcher_top_tb failed");
        $finish;
    end

    initial begin : stimulus
        int n;
        int bias;
        logic cmd;
        logic [3:0] wid;
        logic [4:0] count;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                set_worker_count(directed_rows[i].cfg_val);
            end else begin
                offer_command(directed_rows[i].cmd, directed_rows[i].task_id,
                              directed_rows[i].task_type, directed_rows[i].worker_id,
                              directed_rows[i].kind == ROW_TYPED, directed_rows[i].want);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            source_idle_pct <= (mode == 0) ? 8 : (mode == 1) ? 77 : 0;
            sink_idle_pct <= (mode == 0) ? 77 : (mode == 1) ? 8 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                // The first segment of each mode uses few workers and mostly submits,
                // which drives the store to full and into drops.
                if (seg == 0) begin
                    count = 5'($urandom_range(1, 4));
                    bias = 92;
                end else begin
                    case ($urandom_range(5))
                        0: count = 5'd0;
                        1: count = 5'd16;
                        2: count = 5'd31;
                        3: count = 5'd17;
                        default: count = 5'($urandom_range(1, 8));
                    endcase
                    bias = bias_menu[$urandom_range(3)];
                end
                set_worker_count(count);
                if (seg == 1) begin
                    hold_req <= hold_req + 1;
                end
                n = (seg == 0) ? 110 : 60;
                for (int k = 0; k < n; k++) begin
                    cmd = ($urandom_range(99) < bias) ? wtd_pkg::CMD_SUBMIT
                                                      : wtd_pkg::CMD_COMPLETE;
                    if (cmd == wtd_pkg::CMD_COMPLETE && $urandom_range(99) < 85) begin
                        wid = 4'($urandom_range(live_workers() - 1));
                    end else begin
                        wid = 4'($urandom_range(15));
                    end
                    offer_command(cmd, 16'($urandom), 16'($urandom), wid, 1'b0, '0);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_dispatches.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("worker_task_dispatcher_top_tb passed");
        end else begin
            $display("worker_task_dispatcher_top_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/wtd_pkg.sv
design/wtd_front.sv
design/wtd_queue.sv
design/wtd_back.sv
design/worker_task_dispatcher_top.sv
tb/worker_task_dispatcher_top_tb.sv
